/* hdl/cbn_pkg.sv */
package cbn_pkg;

    localparam int MAX_CHANNELS = 256;
    localparam int MAX_TIMES    = 64;
    localparam int SAMPLE_BITS  = 16;

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_TIMES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PTR_W       = STORE_AW + 1;
    localparam int CH_W        = $clog2(MAX_CHANNELS);
    localparam int NC_W        = CH_W + 1;
    localparam int NT_W        = $clog2(MAX_TIMES) + 1;
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_TIMES);
    localparam int RATIO_W     = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PROD_W      = SAMPLE_BITS + NT_W;
    localparam int NUM_W       = PROD_W + FRAC_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TIMES    = 2'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

    typedef enum logic [1:0] {
        STATUS_LOAD_OK  = 2'd0,
        STATUS_READ_OK  = 2'd1,
        STATUS_READ_SAT = 2'd2,
        STATUS_REJECT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

/* hdl/cbn_ram.sv */
module cbn_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/cbn_divider.sv */
module cbn_divider import cbn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [SUM_W-1:0]   den,
    output logic               done,
    output logic [RATIO_W-1:0] quot
);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // num < den * 2^RATIO_W, so the upper bits of num start below den.
    localparam int REM_W = SUM_W + 1;
    localparam int CNT_W = $clog2(RATIO_W) + 1;

    logic [REM_W-1:0]   rem_reg;
    logic [RATIO_W-1:0] low_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [REM_W-1:0]   shifted;
    logic [REM_W:0]     diff;
    logic               fits;

    assign shifted = {rem_reg[REM_W-2:0], low_reg[RATIO_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, den_reg};
    assign fits    = !diff[REM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(RATIO_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= REM_W'(num[NUM_W-1:RATIO_W]);
            low_reg <= num[RATIO_W-1:0];
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? diff[REM_W-1:0] : shifted;
            low_reg <= {low_reg[RATIO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

/* hdl/channel_bandpass_normalizer.sv */
// Bandpass normalizer for one filterbank frame. Load transfers (s_tuser 0)
// write samples time-major, num_channels per row and num_times rows; each is
// stored and added to its channel's sum. Once the frame is full, read
// transfers (s_tuser 1) return the samples in load order as unsigned Q8.8
// sample * num_times * 256 / channel_sum, truncated; a zero sum or a ratio
// above 65535 gives 65535 with status 2. Loads into a full frame and reads of
// an incomplete frame return status 3 and change nothing. The final read, and
// any write to num_channels or num_times, discard the frame. Each item has
// its sample and sum memory words read, then its result placed; a read that
// divides first runs the 16-step serial divider and its handoff. The result
// then moves to the output register. The next input can be taken in the
// cycle after the result has been placed in the output register, even while
// that result still waits for m_tready, so a new item is not taken until the
// previous item's result is in the output register.
module channel_bandpass_normalizer import cbn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample
    input  logic                  s_tuser,   // [0] func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] ratio
    output logic [1:0]            m_tuser,   // [1:0] status
    output logic                  m_tlast,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [NC_W-1:0]   nc_reg;
    logic [NT_W-1:0]   nt_reg;
    logic [PTR_W-1:0]  load_ptr_reg;
    logic [PTR_W-1:0]  read_ptr_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [MAX_CHANNELS-1:0] sum_valid_reg;

    logic              func_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic              reject_reg;
    logic              sum_hit_reg;

    logic [RATIO_W-1:0] res_ratio_reg;
    status_t           res_status_reg;
    logic              res_last_reg;

    logic              m_valid_reg;
    logic [RATIO_W-1:0] m_data_reg;
    status_t           m_status_reg;
    logic              m_last_reg;

    logic              s_xfer, cfg_xfer, out_free;
    logic              start_div, div_done;
    logic [RATIO_W-1:0] div_quot;

    logic [PTR_W-1:0]  size;
    logic [SAMPLE_BITS-1:0] store_rdata;
    logic [SUM_W-1:0]  sum_rdata;
    logic [SUM_W-1:0]  sum_cur;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;
    logic              sat;
    logic [CH_W-1:0]   ch_next;
    logic [NC_W-1:0]   ch_inc;
    logic              final_read;
    logic              fetch_load, fetch_read;

    assign size     = PTR_W'(nc_reg) * PTR_W'(nt_reg);
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_xfer) state_next = ST_FETCH;
            ST_FETCH: begin
                if (!reject_reg && func_reg == FUNC_READ && !sat) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake and step strobes
    always_comb begin
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        fetch_load = 1'b0;
        fetch_read = 1'b0;
        start_div  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cfg_ready = !s_tvalid;
            end
            ST_FETCH: begin
                fetch_load = !reject_reg && func_reg == FUNC_LOAD;
                fetch_read = !reject_reg && func_reg == FUNC_READ;
                start_div  = fetch_read && !sat;
            end
            default: ;
        endcase
    end

    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_xfer = cfg_valid && cfg_ready;

    cbn_ram #(.DEPTH(STORE_DEPTH), .WIDTH(SAMPLE_BITS)) u_store (
        .aclk  (aclk),
        .we    (fetch_load),
        .waddr (load_ptr_reg[STORE_AW-1:0]),
        .wdata (sample_reg),
        .raddr (read_ptr_reg[STORE_AW-1:0]),
        .rdata (store_rdata)
    );

    cbn_ram #(.DEPTH(MAX_CHANNELS), .WIDTH(SUM_W)) u_sums (
        .aclk  (aclk),
        .we    (fetch_load),
        .waddr (ch_reg),
        .wdata (sum_cur + SUM_W'(sample_reg)),
        .raddr (ch_reg),
        .rdata (sum_rdata)
    );

    // an entry cleared since its last write reads as zero
    assign sum_cur    = sum_hit_reg ? sum_rdata : '0;
    assign prod       = PROD_W'(store_rdata) * PROD_W'(nt_reg);
    assign num        = {prod, FRAC_BITS'(0)};
    assign sat        = (sum_cur == '0) ||
                        ({7'b0, num} >= {sum_cur, RATIO_W'(0)});
    assign ch_inc     = {1'b0, ch_reg} + 1'b1;
    assign ch_next    = (ch_inc >= nc_reg) ? '0 : ch_inc[CH_W-1:0];
    assign final_read = (read_ptr_reg + 1'b1) >= size;

    cbn_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_div),
        .num     (num),
        .den     (sum_cur),
        .done    (div_done),
        .quot    (div_quot)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nc_reg        <= NC_W'(MAX_CHANNELS);
            nt_reg        <= NT_W'(MAX_TIMES);
            load_ptr_reg  <= '0;
            read_ptr_reg  <= '0;
            ch_reg        <= '0;
            sum_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_xfer && (cfg_index == REG_NUM_CHANNELS ||
                             cfg_index == REG_NUM_TIMES)) begin
                // a write to num_channels or num_times discards the frame
                load_ptr_reg  <= '0;
                read_ptr_reg  <= '0;
                ch_reg        <= '0;
                sum_valid_reg <= '0;
                if (cfg_index == REG_NUM_CHANNELS) begin
                    if (cfg_data == '0) begin
                        nc_reg <= NC_W'(1);
                    end else if (cfg_data > CFG_DATA_W'(MAX_CHANNELS)) begin
                        nc_reg <= NC_W'(MAX_CHANNELS);
                    end else begin
                        nc_reg <= NC_W'(cfg_data);
                    end
                end else begin
                    if (cfg_data[NT_W-1:0] == '0) begin
                        nt_reg <= NT_W'(1);
                    end else if (cfg_data[NT_W-1:0] > NT_W'(MAX_TIMES)) begin
                        nt_reg <= NT_W'(MAX_TIMES);
                    end else begin
                        nt_reg <= cfg_data[NT_W-1:0];
                    end
                end
            end
            if (fetch_load) begin
                load_ptr_reg           <= load_ptr_reg + 1'b1;
                ch_reg                 <= ch_next;
                sum_valid_reg[ch_reg]  <= 1'b1;
            end
            if (fetch_read) begin
                if (final_read) begin
                    load_ptr_reg  <= '0;
                    read_ptr_reg  <= '0;
                    ch_reg        <= '0;
                    sum_valid_reg <= '0;
                end else begin
                    read_ptr_reg <= read_ptr_reg + 1'b1;
                    ch_reg       <= ch_next;
                end
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            func_reg    <= s_tuser;
            sample_reg  <= s_tdata[SAMPLE_BITS-1:0];
            sum_hit_reg <= sum_valid_reg[ch_reg];
            // hold rejects: load into a full frame, read of a partial one
            reject_reg  <= (s_tuser == FUNC_LOAD) ? (load_ptr_reg >= size)
                                                  : (load_ptr_reg < size);
        end
        if (state_reg == ST_FETCH) begin
            res_ratio_reg  <= (fetch_read && sat) ? RATIO_SAT : '0;
            res_last_reg   <= fetch_load ? ((load_ptr_reg + 1'b1) == size)
                                         : (fetch_read && final_read);
            res_status_reg <= fetch_load  ? STATUS_LOAD_OK  :
                              !fetch_read ? STATUS_REJECT   :
                              sat         ? STATUS_READ_SAT : STATUS_READ_OK;
        end
        if (state_reg == ST_DIV && div_done) begin
            res_ratio_reg  <= div_quot;
            res_status_reg <= STATUS_READ_OK;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg   <= res_ratio_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hdl/cbn_checker.sv */
module cbn_checker import cbn_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_LOAD_OK |-> m_tdata == '0)
        else $error("load result carries a ratio");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_REJECT |-> m_tdata == '0 && !m_tlast)
        else $error("rejected result not clean");

    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_READ_SAT |-> m_tdata == RATIO_SAT)
        else $error("saturated read without full-scale ratio");

endmodule

bind channel_bandpass_normalizer cbn_checker u_cbn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/channel_bandpass_normalizer_tb.sv */
`timescale 1ns / 1ps

module channel_bandpass_normalizer_tb;
    import cbn_pkg::*;

    typedef struct packed {
        logic        func;
        logic [15:0] sample;
    } bin_item_t;

    typedef struct packed {
        logic [15:0] ratio;
        status_t     status;
        logic        last;
    } norm_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;    // [15:0] sample
    logic                  s_tuser = 1'b0;  // [0] func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] ratio
    logic [1:0]            m_tuser;         // [1:0] status
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    channel_bandpass_normalizer u_dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: a private copy of the frame, the sums and the pointers.
    logic [15:0]      frame_mem [STORE_DEPTH];
    logic [SUM_W-1:0] chan_sum [MAX_CHANNELS];
    int unsigned      load_ptr, read_ptr, chan_idx;
    int unsigned      reg_channels = MAX_CHANNELS, reg_times = MAX_TIMES;

    bin_item_t    pending_items[$];
    norm_result_t expected_results[$];
    int           errors = 0;
    int           items_queued = 0;
    bit           item_held = 1'b0;
    bit           allow_idle = 1'b1;
    int           src_gap = 0, sink_gap = 0;

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void discard_frame();
        foreach (chan_sum[i]) chan_sum[i] = '0;
        load_ptr = 0;
        read_ptr = 0;
        chan_idx = 0;
    endfunction

    function automatic int unsigned frame_size();
        return clamp_reg(reg_channels, MAX_CHANNELS) * clamp_reg(reg_times, MAX_TIMES);
    endfunction

    // Work out the result of one accepted transfer and advance the frame state.
    function automatic void predict_normalized(logic func, logic [15:0] sample);
        int unsigned       nc, nt, size;
        longint unsigned   num, sum, q;
        norm_result_t      r;
        nc   = clamp_reg(reg_channels, MAX_CHANNELS);
        nt   = clamp_reg(reg_times, MAX_TIMES);
        size = nc * nt;
        r    = '{ratio: '0, status: STATUS_REJECT, last: 1'b0};
        if (func == FUNC_LOAD) begin
            if (load_ptr < size) begin
                frame_mem[load_ptr] = sample;
                chan_sum[chan_idx] += sample;
                load_ptr++;
                chan_idx = (chan_idx + 1 >= nc) ? 0 : chan_idx + 1;
                r.status = STATUS_LOAD_OK;
                r.last   = (load_ptr == size);
            end
        end else if (load_ptr >= size) begin
            sum = chan_sum[chan_idx];
            if (sum == 0) begin
                r.ratio  = RATIO_SAT;
                r.status = STATUS_READ_SAT;
            end else begin
                num = (longint'(frame_mem[read_ptr]) * nt) << FRAC_BITS;
                q   = num / sum;
                r.status = (q > 65535) ? STATUS_READ_SAT : STATUS_READ_OK;
                r.ratio  = (q > 65535) ? RATIO_SAT : q[15:0];
            end
            read_ptr++;
            chan_idx = (chan_idx + 1 >= nc) ? 0 : chan_idx + 1;
            if (read_ptr >= size) begin
                r.last = 1'b1;
                discard_frame();
            end
        end
        expected_results.push_back(r);
    endfunction

    // Input side: hold each item until its transfer, with random gaps between items.
    always @(negedge aclk) begin
        bin_item_t nxt;
        if (aresetn && !item_held) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (allow_idle && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 10);
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                s_tdata   <= nxt.sample;
                s_tuser   <= nxt.func;
                item_held = 1'b1;
            end
            s_tvalid <= item_held;
        end
    end

    // Result side backpressure in bursts.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Predict on each input transfer; check each result transfer against the oldest.
    always @(posedge aclk) begin
        norm_result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            predict_normalized(s_tuser, s_tdata);
            item_held = 1'b0;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result ratio=%h status=%0d last=%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.ratio || m_tuser !== want.status
                        || m_tlast !== want.last) begin
                    errors++;
                    $display({"%0t: mismatch expected ratio=%h status=%0d last=%b,",
                              " got ratio=%h status=%0d last=%b"},
                             $time, want.ratio, want.status, want.last,
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    task automatic push_item(logic func, logic [15:0] sample);
        pending_items.push_back('{func: func, sample: sample});
        items_queued++;
    endtask

    // Wait until every queued item has transferred and every result has come back.
    task automatic wait_drained();
        while (pending_items.size() > 0 || item_held || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        // Mirror the write: unknown indexes leave everything alone.
        if (idx == REG_NUM_CHANNELS) begin
            reg_channels = val & 9'h1FF;
            discard_frame();
        end else if (idx == REG_NUM_TIMES) begin
            reg_times = val & 9'h07F;
            discard_frame();
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(int mode);
        case (mode)
            0:       return 16'($urandom_range(0, 3));
            1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Phase sequencer: directed frames first, then random frames with setting changes.
    initial begin
        int unsigned size, extra, mode, kind, nc_val, nt_val;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset frame: read of an empty frame, extreme loads, read of a partial frame.
        push_item(FUNC_READ, 16'h1234);
        push_item(FUNC_LOAD, 16'h0000);
        push_item(FUNC_LOAD, 16'hFFFF);
        push_item(FUNC_LOAD, 16'h5555);
        push_item(FUNC_LOAD, 16'hAAAA);
        push_item(FUNC_READ, 16'h0000);
        wait_drained();

        // 2x2 frame whose second channel sums to zero; load into the full frame.
        write_reg(REG_NUM_CHANNELS, 9'd2);
        write_reg(REG_NUM_TIMES, 9'd2);
        push_item(FUNC_LOAD, 16'hFFFF);
        push_item(FUNC_LOAD, 16'h0000);
        push_item(FUNC_LOAD, 16'h0001);
        push_item(FUNC_LOAD, 16'h0000);
        push_item(FUNC_LOAD, 16'h7777);
        repeat (4) push_item(FUNC_READ, 16'hFFFF);
        wait_drained();

        // Out of range values and unused indexes.
        write_reg(REG_NUM_CHANNELS, 9'd0);
        write_reg(REG_NUM_TIMES, 9'd0);
        write_reg(2'd2, 9'h1FF);
        write_reg(2'd3, 9'h0AA);
        push_item(FUNC_LOAD, 16'h8000);
        push_item(FUNC_READ, 16'h0000);
        wait_drained();

        kind = 0;
        while (items_queued < 1550) begin
            // Pick a setting; large values on one axis keep the other small.
            case (kind)
                0: begin nc_val = 9'h1FF; nt_val = 9'd0; end
                1: begin nc_val = 9'd1;   nt_val = 9'h1C7; end
                2: begin nc_val = 9'd256; nt_val = 9'd1; end
                3: begin nc_val = 9'd3;   nt_val = 9'd64; end
                default: begin
                    nc_val = $urandom_range(1, 8);
                    nt_val = $urandom_range(1, 8);
                    if ($urandom_range(0, 9) == 0) nt_val = $urandom_range(0, 511);
                    else if ($urandom_range(0, 9) == 0) nc_val = $urandom_range(0, 511);
                end
            endcase
            if (kind < 4 || $urandom_range(0, 3) != 0) begin
                write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(nc_val));
                write_reg(REG_NUM_TIMES, CFG_DATA_W'(nt_val));
            end else begin
                write_reg(CFG_IDX_W'($urandom_range(0, 3)),
                          CFG_DATA_W'($urandom_range(0, 511)));
            end
            kind++;
            // Keep frames bounded, and small near the end so the count stays close.
            if (frame_size() > 512 || (items_queued > 1250 && frame_size() > 16)) begin
                write_reg(REG_NUM_CHANNELS, 9'd4);
                write_reg(REG_NUM_TIMES, 9'd4);
            end
            size = frame_size();
            mode = $urandom_range(0, 2);
            if (items_queued > 1250) allow_idle = 1'b0;

            case ($urandom_range(0, 7))
                0: begin
                    // Noise: random operations on whatever the frame holds.
                    repeat (20) push_item(1'($urandom_range(0, 1)), pick_sample(2));
                end
                1: begin
                    // Broken frame: partly loaded, then discarded by the next write to num_channels or num_times.
                    repeat ($urandom_range(0, size - 1)) begin
                        push_item(FUNC_LOAD, pick_sample(mode));
                        if ($urandom_range(0, 9) == 0) push_item(FUNC_READ, 16'h0000);
                    end
                end
                default: begin
                    for (int i = 0; i < size; i++) begin
                        push_item(FUNC_LOAD, pick_sample(mode));
                        if ($urandom_range(0, 19) == 0) push_item(FUNC_READ, pick_sample(2));
                    end
                    extra = $urandom_range(0, 2);
                    repeat (extra) push_item(FUNC_LOAD, pick_sample(2));
                    for (int i = 0; i < size; i++) push_item(FUNC_READ, pick_sample(2));
                end
            endcase
            wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("channel_bandpass_normalizer_tb OK");
        else
            $display("channel_bandpass_normalizer_tb NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("channel_bandpass_normalizer_tb NOT OK");
        $finish;
    end

endmodule
